### src/assert_macros.svh
// Shared assertion macros; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_PROP(label, !(cond), msg)

`endif

### src/tgfm_pkg.sv
package tgfm_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned CFG_W  = 12;
    localparam int unsigned GRAD_W = 11;
    localparam int unsigned ABS_W  = 10;
    localparam int unsigned SQ_W   = 21;
    localparam int unsigned ACC_W  = 44;
    localparam int unsigned SUM_W  = 43;
    localparam int unsigned BORDER = 2;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef logic signed [GRAD_W-1:0] grad_t;

    typedef struct packed {
        logic interior;
        logic last;
    } tag_t;

endpackage

### src/tgfm_ram.sv
module tgfm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tgfm_sobel.sv
`include "assert_macros.svh"

module tgfm_sobel #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         accept,
    input  logic [tgfm_pkg::PIX_W-1:0]   pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] col,
    input  tgfm_pkg::tag_t               tag_in,
    output logic                         grad_valid,
    output tgfm_pkg::grad_t              gx,
    output tgfm_pkg::grad_t              gy,
    output tgfm_pkg::tag_t               grad_tag
);

    import tgfm_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [AW-1:0]    s1_addr_reg;
    tag_t             s1_tag_reg;

    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    logic [PIX_W-1:0] win_reg [6];

    logic             grad_valid_reg;
    grad_t            gx_reg;
    grad_t            gy_reg;
    tag_t             grad_tag_reg;

    logic [PIX_W-1:0] upper_q;
    logic [PIX_W-1:0] middle_q;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             s1_step;
    grad_t            gx_next;
    grad_t            gy_next;

    assign s1_step = s1_valid_reg && adv;

    tgfm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (s1_step),
        .waddr (s1_addr_reg),
        .wdata (mid),
        .re    (accept),
        .raddr (col),
        .rdata (upper_q)
    );

    tgfm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (s1_step),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col),
        .rdata (middle_q)
    );

    // write of the previous pixel lands on the same column as this read
    assign top = fwd_reg ? fwd_top_reg : upper_q;
    assign mid = fwd_reg ? fwd_mid_reg : middle_q;

    always_comb
    begin
        gx_next = GRAD_W'(top) + (GRAD_W'(mid) << 1) + GRAD_W'(s1_pix_reg)
                - GRAD_W'(win_reg[0]) - (GRAD_W'(win_reg[1]) << 1) - GRAD_W'(win_reg[2]);
        gy_next = GRAD_W'(win_reg[2]) + (GRAD_W'(win_reg[5]) << 1) + GRAD_W'(s1_pix_reg)
                - GRAD_W'(win_reg[0]) - (GRAD_W'(win_reg[3]) << 1) - GRAD_W'(top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            grad_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg   <= accept;
                grad_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                fwd_reg <= s1_valid_reg && (col == s1_addr_reg);
            end
            if (s1_step)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= col;
            s1_tag_reg  <= tag_in;
            fwd_top_reg <= mid;
            fwd_mid_reg <= s1_pix_reg;
        end
        if (s1_step)
        begin
            gx_reg       <= gx_next;
            gy_reg       <= gy_next;
            grad_tag_reg <= s1_tag_reg;
        end
    end

    assign grad_valid = grad_valid_reg;
    assign gx         = gx_reg;
    assign gy         = gy_reg;
    assign grad_tag   = grad_tag_reg;

    `ASSERT_PROP(a_grad_from_s1, $rose(grad_valid_reg) |-> $past(s1_valid_reg),
        "gradient stage filled without a window stage item")

endmodule

### src/tgfm_accum.sv
`include "assert_macros.svh"

module tgfm_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        grad_valid,
    input  tgfm_pkg::grad_t             gx,
    input  tgfm_pkg::grad_t             gy,
    input  tgfm_pkg::tag_t              grad_tag,
    input  logic                        out_stall,
    output logic                        hold,
    output logic                        out_valid,
    output logic [tgfm_pkg::SUM_W-1:0]  focus_sum
);

    import tgfm_pkg::*;

    logic             s3_valid_reg;
    logic [SQ_W-1:0]  s3_sq_reg;
    tag_t             s3_tag_reg;
    logic [ACC_W-1:0] total_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_data_reg;

    logic [ABS_W-1:0] ax;
    logic [ABS_W-1:0] ay;
    logic [SQ_W-1:0]  sq_next;
    logic [ACC_W-1:0] total_next;
    logic             load;
    logic             out_valid_next;

    always_comb
    begin
        ax      = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
        ay      = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
        sq_next = (SQ_W'(ax) * SQ_W'(ax)) + (SQ_W'(ay) * SQ_W'(ay));
    end

    assign total_next = s3_tag_reg.interior ? total_reg + ACC_W'(s3_sq_reg) : total_reg;
    assign hold       = s3_valid_reg && s3_tag_reg.last && out_valid_reg && out_stall;
    assign load       = adv && s3_valid_reg && s3_tag_reg.last;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s3_valid_reg <= grad_valid;
                if (s3_valid_reg)
                begin
                    total_reg <= s3_tag_reg.last ? '0 : total_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && grad_valid)
        begin
            s3_sq_reg  <= sq_next;
            s3_tag_reg <= grad_tag;
        end
        if (load)
        begin
            out_data_reg <= total_next[SUM_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign focus_sum = out_data_reg;

    `ASSERT_PROP(a_frame_close, load |=> (out_valid_reg && total_reg == '0),
        "frame end did not post result and clear total")

endmodule

### src/tenengrad_focus_measure.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------
// in       | in_valid / in_stall | pixel[7:0]
// out      | out_valid/out_stall | focus_sum[42:0]
// cfg      | cfg_we              | cfg_index, cfg_data[11:0]
//
// One pixel per cycle while in_stall is low; a total passes the s1, gradient and s3 registers.
// Line stores are two RAMs of MAX_WIDTH bytes: one read per transfer, one write from stage s1.
// rst_n is asynchronous; line stores are not cleared and need no clearing pass.
// in_stall rises only when a finished total waits in the output register under out_stall
// and the next frame's end has reached the accumulator.
`include "assert_macros.svh"

module tenengrad_focus_measure #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tgfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgfm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tgfm_pkg::PIX_W-1:0]     pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tgfm_pkg::SUM_W-1:0]     focus_sum
);

    import tgfm_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned WMW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int unsigned HMW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1)
                                                                  : CFG_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;

    logic [WMW-1:0]   w_ext;
    logic [WMW-1:0]   w_eff;
    logic [HMW-1:0]   h_ext;
    logic [HMW-1:0]   h_eff;
    logic             col_end;
    logic             row_end;
    logic             hold;
    logic             adv;
    logic             accept;
    tag_t             tag;

    logic             grad_valid;
    grad_t            gx;
    grad_t            gy;
    tag_t             grad_tag;

    always_comb
    begin
        w_ext = WMW'(frame_width_reg);
        h_ext = HMW'(frame_height_reg);
        if (w_ext == '0)
        begin
            w_eff = WMW'(1);
        end
        else if (w_ext > WMW'(MAX_WIDTH))
        begin
            w_eff = WMW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        if (h_ext == '0)
        begin
            h_eff = HMW'(1);
        end
        else if (h_ext > HMW'(MAX_HEIGHT))
        begin
            h_eff = HMW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end
    end

    assign col_end      = (WMW'(col_reg) + WMW'(1)) >= w_eff;
    assign row_end      = (HMW'(row_reg) + HMW'(1)) >= h_eff;
    assign adv          = !hold;
    assign in_stall     = hold;
    assign accept       = in_valid && adv;
    assign tag.interior = (col_reg >= CW'(BORDER)) && (row_reg >= RW'(BORDER));
    assign tag.last     = col_end && row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    tgfm_sobel #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_sobel (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .accept     (accept),
        .pixel      (pixel),
        .col        (col_reg),
        .tag_in     (tag),
        .grad_valid (grad_valid),
        .gx         (gx),
        .gy         (gy),
        .grad_tag   (grad_tag)
    );

    tgfm_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .grad_valid (grad_valid),
        .gx         (gx),
        .gy         (gy),
        .grad_tag   (grad_tag),
        .out_stall  (out_stall),
        .hold       (hold),
        .out_valid  (out_valid),
        .focus_sum  (focus_sum)
    );

    `ASSERT_PROP(a_frame_wrap, (accept && tag.last) |=> (col_reg == '0 && row_reg == '0),
        "counters did not wrap at frame end")
    `ASSERT_NEVER(a_stall_cause, in_stall && !(out_valid && out_stall),
        "input stalled without a blocked result")

endmodule

### tb/sv/focus_sum_checker.sv
module focus_sum_checker
    import tgfm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [SUM_W-1:0]     focus_sum,
    output int                   mismatches,
    output int                   sums_waiting,
    output int                   sums_checked
);

    logic [CFG_W-1:0] width_setting;
    logic [CFG_W-1:0] height_setting;
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    // slot: column (0 = c-2, 1 = c-1) * 3 + row (0 top, 1 middle, 2 bottom)
    logic [PIX_W-1:0] prev_cols [6];
    int unsigned      col;
    int unsigned      row;
    logic [ACC_W-1:0] frame_energy;
    logic [SUM_W-1:0] expected_sums [$];

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return 32'(v);
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] bot);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        int               gx;
        int               gy;
        w = clamp_dim(width_setting, MAX_WIDTH);
        h = clamp_dim(height_setting, MAX_HEIGHT);
        top_px = older_row[col];
        mid_px = newer_row[col];
        older_row[col] = mid_px;
        newer_row[col] = bot;
        if (col >= 2 && row >= 2)
        begin
            gx = int'(top_px) + 2 * int'(mid_px) + int'(bot)
               - int'(prev_cols[0]) - 2 * int'(prev_cols[1]) - int'(prev_cols[2]);
            gy = int'(prev_cols[2]) + 2 * int'(prev_cols[5]) + int'(bot)
               - int'(prev_cols[0]) - 2 * int'(prev_cols[3]) - int'(top_px);
            frame_energy = frame_energy + ACC_W'(gx * gx + gy * gy);
        end
        prev_cols[0] = prev_cols[3];
        prev_cols[1] = prev_cols[4];
        prev_cols[2] = prev_cols[5];
        prev_cols[3] = top_px;
        prev_cols[4] = mid_px;
        prev_cols[5] = bot;
        if (col + 1 >= w)
        begin
            col = 0;
            if (row + 1 >= h)
            begin
                expected_sums.push_back(frame_energy[SUM_W-1:0]);
                frame_energy = '0;
                row = 0;
            end
            else
            begin
                row++;
            end
        end
        else
        begin
            col++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [SUM_W-1:0] want;
        if (!rst_n)
        begin
            width_setting = FRAME_WIDTH_RST;
            height_setting = FRAME_HEIGHT_RST;
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (prev_cols[i])
            begin
                prev_cols[i] = '0;
            end
            col = 0;
            row = 0;
            frame_energy = '0;
            expected_sums.delete();
            mismatches = 0;
            sums_checked = 0;
            sums_waiting <= 0;
        end
        else
        begin
            // a transfer at the same edge as a write still sees the old size
            if (in_valid && !in_stall)
            begin
                take_pixel(pixel);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    width_setting = cfg_data;
                end
                else if (cfg_index == REG_FRAME_HEIGHT)
                begin
                    height_setting = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected focus_sum transfer: expected none, actual %0d",
                             $time, focus_sum);
                    mismatches++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    sums_checked++;
                    if (focus_sum !== want)
                    begin
                        $display("%0t: focus_sum mismatch: expected %0d, actual %0d",
                                 $time, want, focus_sum);
                        mismatches++;
                    end
                end
            end
            sums_waiting <= expected_sums.size();
        end
    end

endmodule

### tb/sv/tb_tenengrad_focus_measure.sv
module tb_tenengrad_focus_measure;
    import tgfm_pkg::*;

    localparam int unsigned DRAIN_SLACK   = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned RANDOM_PIXELS = 800;
    localparam int unsigned RANDOM_FRAMES = 25;

    typedef enum int unsigned {TEX_RANDOM, TEX_EXTREME, TEX_SMOOTH, TEX_FLAT} texture_e;
    typedef enum int unsigned {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel;
    logic                 out_valid;
    logic                 out_stall;
    logic [SUM_W-1:0]     focus_sum;

    int          mismatches;
    int          sums_waiting;
    int          sums_checked;
    int          holds_asked;
    int          holds_done;
    int unsigned burst_left;
    bit          steady;
    int unsigned pixels_sent;

    always #1 clk = ~clk;

    tenengrad_focus_measure uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .focus_sum (focus_sum)
    );

    focus_sum_checker sum_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .focus_sum    (focus_sum),
        .mismatches   (mismatches),
        .sums_waiting (sums_waiting),
        .sums_checked (sums_checked)
    );

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic send_frame(input int unsigned count, input texture_e tex);
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] value;
        base = PIX_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < count; i++)
        begin
            case (tex)
                TEX_EXTREME: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                TEX_SMOOTH:  value = base ^ PIX_W'($urandom_range(0, 3));
                TEX_FLAT:    value = base;
                default:     value = PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(value);
        end
    endtask

    // no transfer in flight: pending totals out, then the pipeline tail
    task automatic wait_for_totals();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sums_waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int unsigned frame_px, input int unsigned frames);
        set_frame_size(w, h);
        for (int unsigned f = 0; f < frames; f++)
        begin
            send_frame(frame_px, texture_e'($urandom_range(0, 3)));
        end
        wait_for_totals();
    endtask

    initial
    begin
        int unsigned      span;
        sink_mode_e       mode;
        out_stall = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_asked > holds_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            mode = sink_mode_e'($urandom_range(0, 3));
            span = $urandom_range(4, 120);
            for (int unsigned k = 0; k < span && holds_asked == holds_done; k++)
            begin
                case (mode)
                    SINK_OPEN:  out_stall <= 1'b0;
                    SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:    out_stall <= ~out_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("tb_tenengrad_focus_measure: FAIL");
        $finish;
    end

    initial
    begin
        int unsigned      rand_px;
        int unsigned      rand_frames;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int unsigned      frames;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        holds_asked = 0;
        burst_left = 0;
        steady = 1'b0;
        pixels_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame: vertical edge, reversed edge, horizontal edge
        set_frame_size(12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i % 3 == 0) ? 8'hFF : 8'h00);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i >= 6) ? 8'hFF : 8'h00);
        end
        wait_for_totals();

        // sizes below the interior minimum; a zero size is clamped to one
        run_phase(12'd0, 12'd3, 3, 2);
        run_phase(12'd2, 12'd3, 6, 2);
        run_phase(12'd4, 12'd0, 4, 2);
        run_phase(12'd4, 12'd2, 8, 2);
        run_phase(12'd1, 12'd1, 1, 30);

        // size change mid-frame: column past the new last column ends the row and the frame
        set_frame_size(12'd6, 12'd6);
        send_frame(16, TEX_RANDOM);
        wait_for_totals();
        set_frame_size(12'd4, 12'd3);
        send_frame(1, TEX_RANDOM);
        wait_for_totals();

        // height shrinks below the current row: that row becomes the last
        set_frame_size(12'd5, 12'd8);
        send_frame(22, TEX_RANDOM);
        wait_for_totals();
        set_frame_size(12'd5, 12'd3);
        send_frame(3, TEX_RANDOM);
        wait_for_totals();

        // sizes above the limit clamp and keep the row and frame open
        set_frame_size(12'd4095, 12'd4095);
        send_frame(40, TEX_RANDOM);
        wait_for_totals();
        set_frame_size(12'd3, 12'd3);
        send_frame(7, TEX_RANDOM);
        wait_for_totals();
        set_frame_size(12'd3, 12'd4095);
        send_frame(30, TEX_RANDOM);
        wait_for_totals();
        set_frame_size(12'd3, 12'd3);
        send_frame(3, TEX_RANDOM);
        wait_for_totals();

        // long output hold-off while small frames keep coming
        set_frame_size(12'd3, 12'd3);
        holds_asked <= holds_asked + 1;
        for (int f = 0; f < 20; f++)
        begin
            send_frame(9, texture_e'($urandom_range(0, 3)));
        end
        wait_for_totals();

        rand_px = 0;
        rand_frames = 0;
        while (rand_px < RANDOM_PIXELS || rand_frames < RANDOM_FRAMES)
        begin
            w = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 9));
            h = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 7));
            frames = $urandom_range(1, 4);
            steady = ($urandom_range(0, 3) == 0);
            run_phase(w, h, w * h, frames);
            rand_px += w * h * frames;
            rand_frames += frames;
        end
        steady = 1'b0;

        wait_for_totals();
        $display("Covered %0d pixels and %0d focus totals: frames from 1x1 up, clamped sizes,",
                 pixels_sent, sums_checked);
        $display("mid-frame size changes, random gaps and stalls, and a long output hold-off.");
        if (mismatches == 0 && sums_waiting == 0)
        begin
            $display("tb_tenengrad_focus_measure: PASS");
        end
        else
        begin
            $display("tb_tenengrad_focus_measure: FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/tgfm_pkg.sv
src/tgfm_ram.sv
src/tgfm_sobel.sv
src/tgfm_accum.sv
src/tenengrad_focus_measure.sv
tb/sv/focus_sum_checker.sv
tb/sv/tb_tenengrad_focus_measure.sv
